/* hdl/wsct_pkg.sv */
// ---------------------------------------------------------------------------
// wsct_pkg
// Shared constants, action codes and types of the weighted slot cache table.
// ---------------------------------------------------------------------------
package wsct_pkg;

  localparam int SLOT_COUNT = 8;
  localparam int IDX_W      = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int CNT_W      = $clog2(SLOT_COUNT + 1);

  localparam int ACT_W = 3;
  localparam int KEY_W = 32;
  localparam int ID_W  = 16;
  localparam int WT_W  = 16;
  localparam int REL_W = 4;

  localparam logic [WT_W-1:0]  OFFER_LIMIT = WT_W'(10);
  localparam logic [REL_W-1:0] REL_MAX     = '1;

  localparam logic [ACT_W-1:0] ACT_LOOKUP_KEY = 3'd0;
  localparam logic [ACT_W-1:0] ACT_LOOKUP_ID  = 3'd1;
  localparam logic [ACT_W-1:0] ACT_PUT        = 3'd2;
  localparam logic [ACT_W-1:0] ACT_INVALIDATE = 3'd3;
  localparam logic [ACT_W-1:0] ACT_CLEAR      = 3'd4;
  localparam logic [ACT_W-1:0] ACT_OFFER      = 3'd5;

  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = 1;
  localparam logic [CFG_IDX_W-1:0] REG_CACHE_ENABLE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_PUT_LOCK     = 1'b1;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [ID_W-1:0]  id;
    logic [WT_W-1:0]  weight;
  } slot_t;

  localparam int SLOT_W = $bits(slot_t);

  typedef struct packed {
    logic             hit;
    logic [ID_W-1:0]  found_id;
    logic [WT_W-1:0]  new_weight;
    logic             accepted;
    logic             evicted;
    logic [ID_W-1:0]  evicted_id;
    logic [REL_W-1:0] released;
  } res_t;

endpackage

/* hdl/wsct_if.sv */
// ---------------------------------------------------------------------------
// wsct_if
// Valid/ready channels of the slot table: action beats in, result beats out.
// ---------------------------------------------------------------------------
interface wsct_in_if;
  logic                       valid;
  logic                       ready;
  logic [wsct_pkg::ACT_W-1:0] action;
  logic [wsct_pkg::KEY_W-1:0] entry_key;
  logic [wsct_pkg::ID_W-1:0]  entry_id;
  logic [wsct_pkg::WT_W-1:0]  entry_weight;

  modport source (output valid, action, entry_key, entry_id, entry_weight, input ready);
  modport sink   (input valid, action, entry_key, entry_id, entry_weight, output ready);
endinterface

interface wsct_out_if;
  logic                       valid;
  logic                       ready;
  logic                       hit;
  logic [wsct_pkg::ID_W-1:0]  found_id;
  logic [wsct_pkg::WT_W-1:0]  new_weight;
  logic                       accepted;
  logic                       evicted;
  logic [wsct_pkg::ID_W-1:0]  evicted_id;
  logic [wsct_pkg::REL_W-1:0] released;

  modport source (output valid, hit, found_id, new_weight, accepted, evicted, evicted_id,
                  released, input ready);
  modport sink   (input valid, hit, found_id, new_weight, accepted, evicted, evicted_id,
                  released, output ready);
endinterface

/* hdl/wsct_ram.sv */
// ---------------------------------------------------------------------------
// wsct_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module wsct_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 8,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* hdl/weighted_slot_cache_table_core.sv */
// ---------------------------------------------------------------------------
// weighted_slot_cache_table_core
// Fully associative slot table; slot words live in a RAM and are scanned
// one slot per cycle with read-modify-write, valid bits in flops.
// ---------------------------------------------------------------------------
//  channel | dir | beat
//  --------+-----+-------------------------------------------------------
//  in_i    | in  | action, entry_key, entry_id, entry_weight
//  out_o   | out | hit, found_id, new_weight, accepted, evicted, evicted_id,
//          |     | released
//  cfg     | in  | cfg_we_i, cfg_idx_i, cfg_data_i (write only)
//
// One beat at a time: the single RAM read port visits one slot per cycle,
// plus read latency and result handoff.
// Input is taken only between beats; a result waiting on out_o holds the
// next result in the core but not the next input beat. Reset clears valid
// bits and put lock, sets free count full and cache on; RAM needs none.
// ---------------------------------------------------------------------------
module weighted_slot_cache_table_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  wsct_in_if.sink                         in_i,
  wsct_out_if.source                      out_o,
  input  logic                            cfg_we_i,
  input  logic [wsct_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [wsct_pkg::CFG_W-1:0]      cfg_data_i
);

  typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_HOLD} state_e;

  state_e                           state_q;
  logic [wsct_pkg::CNT_W-1:0]       iss_q;
  logic                             evl_q;
  logic [wsct_pkg::IDX_W-1:0]       evl_idx_q;
  logic [wsct_pkg::SLOT_COUNT-1:0]  valid_q;
  logic [wsct_pkg::CNT_W-1:0]       free_q;
  logic                             en_q;
  logic                             lock_q;

  logic [wsct_pkg::ACT_W-1:0]       act_q;
  logic [wsct_pkg::KEY_W-1:0]       key_q;
  logic [wsct_pkg::ID_W-1:0]        id_q;
  logic [wsct_pkg::WT_W-1:0]        wt_q;
  logic                             ok_q;
  logic                             done_q;
  wsct_pkg::res_t                   res_q;

  logic                             out_valid_q;
  wsct_pkg::res_t                   out_res_q;

  logic                             ok_in;
  wsct_pkg::res_t                   res_init;
  logic                             issue;
  logic                             last_evl;
  logic [wsct_pkg::SLOT_W-1:0]      rdata;
  wsct_pkg::slot_t                  rd_slot;
  wsct_pkg::slot_t                  wr_slot;
  logic                             wr_en;
  logic                             vld_set;
  logic                             vld_clr;
  logic                             free_inc;
  logic                             free_dec;
  logic                             done_d;
  wsct_pkg::res_t                   res_d;
  logic                             cur_vld;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q   <= 1'b1;
      lock_q <= 1'b0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == wsct_pkg::REG_CACHE_ENABLE) begin
        en_q <= cfg_data_i[0];
      end else if (cfg_idx_i == wsct_pkg::REG_PUT_LOCK) begin
        lock_q <= cfg_data_i[0];
      end
    end
  end

  always_comb begin
    unique case (in_i.action)
      wsct_pkg::ACT_LOOKUP_KEY: ok_in = en_q && (in_i.entry_key != '0);
      wsct_pkg::ACT_LOOKUP_ID:  ok_in = en_q;
      wsct_pkg::ACT_PUT:        ok_in = en_q && !lock_q && (free_q != '0);
      wsct_pkg::ACT_INVALIDATE: ok_in = (in_i.entry_key != '0);
      wsct_pkg::ACT_CLEAR:      ok_in = 1'b1;
      wsct_pkg::ACT_OFFER:      ok_in = (in_i.entry_weight <= wsct_pkg::OFFER_LIMIT);
      default:                  ok_in = 1'b0;
    endcase
  end

  always_comb begin
    res_init = '0;
    if ((in_i.action == wsct_pkg::ACT_OFFER) &&
        (in_i.entry_weight > wsct_pkg::OFFER_LIMIT)) begin
      res_init.new_weight = in_i.entry_weight;
    end
  end

  assign issue    = (state_q == ST_RUN) && (iss_q < wsct_pkg::CNT_W'(wsct_pkg::SLOT_COUNT));
  assign last_evl = evl_q && (evl_idx_q == wsct_pkg::IDX_W'(wsct_pkg::SLOT_COUNT - 1));

  wsct_ram #(
    .WIDTH (wsct_pkg::SLOT_W),
    .DEPTH (wsct_pkg::SLOT_COUNT)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (evl_idx_q),
    .wdata_i (wr_slot),
    .raddr_i (iss_q[wsct_pkg::IDX_W-1:0]),
    .rdata_o (rdata)
  );

  assign rd_slot = wsct_pkg::slot_t'(rdata);
  assign cur_vld = valid_q[evl_idx_q];

  // per-slot evaluation of the slot whose word just came back
  always_comb begin
    wr_en    = 1'b0;
    wr_slot  = rd_slot;
    vld_set  = 1'b0;
    vld_clr  = 1'b0;
    free_inc = 1'b0;
    free_dec = 1'b0;
    done_d   = done_q;
    res_d    = res_q;
    if (evl_q && ok_q && !done_q) begin
      unique case (act_q)
        wsct_pkg::ACT_LOOKUP_KEY: begin
          if (cur_vld && (rd_slot.key == key_q)) begin
            wr_en = 1'b1;
            if (rd_slot.weight != '1) begin
              wr_slot.weight = rd_slot.weight + wsct_pkg::WT_W'(1);
            end
            res_d.hit        = 1'b1;
            res_d.found_id   = rd_slot.id;
            res_d.new_weight = wr_slot.weight;
            done_d           = 1'b1;
          end
        end
        wsct_pkg::ACT_LOOKUP_ID: begin
          if (cur_vld && (rd_slot.id == id_q)) begin
            res_d.hit      = 1'b1;
            res_d.found_id = rd_slot.id;
            done_d         = 1'b1;
          end
        end
        wsct_pkg::ACT_PUT: begin
          if (!cur_vld) begin
            wr_en          = 1'b1;
            wr_slot        = '{key: key_q, id: id_q, weight: wt_q};
            vld_set        = 1'b1;
            free_dec       = 1'b1;
            res_d.accepted = 1'b1;
            done_d         = 1'b1;
          end
        end
        wsct_pkg::ACT_INVALIDATE, wsct_pkg::ACT_CLEAR: begin
          if (cur_vld && ((act_q == wsct_pkg::ACT_CLEAR) || (rd_slot.key == key_q))) begin
            vld_clr  = 1'b1;
            free_inc = 1'b1;
            if (res_q.released != wsct_pkg::REL_MAX) begin
              res_d.released = res_q.released + wsct_pkg::REL_W'(1);
            end
          end
        end
        wsct_pkg::ACT_OFFER: begin
          if (!cur_vld || (rd_slot.weight < wsct_pkg::OFFER_LIMIT)) begin
            wr_en          = 1'b1;
            wr_slot        = '{key: key_q, id: id_q, weight: '0};
            res_d.accepted = 1'b1;
            done_d         = 1'b1;
            if (!cur_vld) begin
              vld_set  = 1'b1;
              free_dec = (free_q != '0);
            end else begin
              res_d.evicted    = 1'b1;
              res_d.evicted_id = rd_slot.id;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      iss_q       <= '0;
      evl_q       <= 1'b0;
      evl_idx_q   <= '0;
      valid_q     <= '0;
      free_q      <= wsct_pkg::CNT_W'(wsct_pkg::SLOT_COUNT);
      act_q       <= '0;
      key_q       <= '0;
      id_q        <= '0;
      wt_q        <= '0;
      ok_q        <= 1'b0;
      done_q      <= 1'b0;
      res_q       <= '0;
      out_valid_q <= 1'b0;
      out_res_q   <= '0;
    end else begin
      if ((state_q == ST_HOLD) && (!out_valid_q || out_o.ready)) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (vld_set) begin
        valid_q[evl_idx_q] <= 1'b1;
      end else if (vld_clr) begin
        valid_q[evl_idx_q] <= 1'b0;
      end
      if (free_inc) begin
        free_q <= free_q + wsct_pkg::CNT_W'(1);
      end else if (free_dec) begin
        free_q <= free_q - wsct_pkg::CNT_W'(1);
      end
      unique case (state_q)
        ST_IDLE: begin
          evl_q <= 1'b0;
          if (in_i.valid) begin
            act_q   <= in_i.action;
            key_q   <= in_i.entry_key;
            id_q    <= in_i.entry_id;
            wt_q    <= in_i.entry_weight;
            ok_q    <= ok_in;
            done_q  <= 1'b0;
            iss_q   <= '0;
            res_q   <= res_init;
            state_q <= ST_RUN;
          end
        end
        ST_RUN: begin
          res_q     <= res_d;
          done_q    <= done_d;
          evl_q     <= issue;
          evl_idx_q <= iss_q[wsct_pkg::IDX_W-1:0];
          if (issue) begin
            iss_q <= iss_q + wsct_pkg::CNT_W'(1);
          end
          if (last_evl) begin
            state_q <= ST_HOLD;
          end
        end
        ST_HOLD: begin
          if (!out_valid_q || out_o.ready) begin
            out_res_q <= res_q;
            state_q   <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_i.ready       = (state_q == ST_IDLE);
  assign out_o.valid      = out_valid_q;
  assign out_o.hit        = out_res_q.hit;
  assign out_o.found_id   = out_res_q.found_id;
  assign out_o.new_weight = out_res_q.new_weight;
  assign out_o.accepted   = out_res_q.accepted;
  assign out_o.evicted    = out_res_q.evicted;
  assign out_o.evicted_id = out_res_q.evicted_id;
  assign out_o.released   = out_res_q.released;

  a_free_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    free_q <= wsct_pkg::CNT_W'(wsct_pkg::SLOT_COUNT))
    else $error("free count above slot count");

  a_free_matches_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> (int'(free_q) == wsct_pkg::SLOT_COUNT - $countones(valid_q)))
    else $error("free count out of step with valid bits");

  a_evict_accepts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.evicted) |-> out_o.accepted)
    else $error("eviction without placement");

  a_hit_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.hit) |-> (!out_o.accepted && (out_o.released == '0)))
    else $error("lookup hit mixed with other result");

endmodule
